// File: hdl/lfu_pkg.sv
// Shared types and constants for the LFU cache lookup/insert block.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;

    localparam int STAMP_BITS = 48;
    localparam int CAP_BITS   = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // request accepted this cycle
        logic scan;    // slot scan running
        logic commit;  // write back and present the result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic refuse;     // put with capacity zero at the request inputs
        logic scan_done;  // last slot compared this cycle
    } t_dp_stat;

endpackage
`default_nettype wire

// File: hdl/lfu_ctrl.sv
// Sequencer for accept, slot scan and write-back.
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl
    import lfu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output logic          o_busy,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = i_stat.refuse ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy        = 1'b1;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_FIN: begin
                o_cmd.commit = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    a_fin_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN |=> r_state == ST_IDLE)
        else $error("write-back state held more than one cycle");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_stat.scan_done) |=> r_state == ST_FIN)
        else $error("scan end did not lead to write-back");

endmodule
`default_nettype wire

// File: hdl/lfu_dp.sv
// Slot memories, scan accumulators, write-back and result registers.
`timescale 1ns / 1ps
`default_nettype none
module lfu_dp
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic                  i_cfg_we,
    input  wire logic [CAP_BITS-1:0]   i_cfg_wdata,
    input  wire logic                  i_mode,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic                       o_done,
    output logic                       o_hit,
    output logic [VALUE_BITS-1:0]      o_read_value,
    output logic                       o_evicted,
    output logic [KEY_BITS-1:0]        o_evicted_key,
    output logic                       o_refused
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (UW > CAP_BITS) ? UW : CAP_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // slot storage
    logic [KEY_BITS-1:0]   r_mem_key   [ENTRIES];
    logic [VALUE_BITS-1:0] r_mem_value [ENTRIES];
    logic [COUNT_BITS-1:0] r_mem_count [ENTRIES];
    logic [STAMP_BITS-1:0] r_mem_stamp [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;

    logic [CAP_BITS-1:0]   r_capacity;
    logic [STAMP_BITS-1:0] r_stamp;

    // latched request
    logic                  r_put;
    logic                  r_refuse;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // scan pipeline
    logic                  r_issue;
    logic [IW-1:0]         r_addr;
    logic                  r_cmp_vld;
    logic [IW-1:0]         r_cmp_idx;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_value;
    logic [COUNT_BITS-1:0] r_rd_count;
    logic [STAMP_BITS-1:0] r_rd_stamp;

    // scan results
    logic                  r_found;
    logic [IW-1:0]         r_found_idx;
    logic [VALUE_BITS-1:0] r_found_value;
    logic [COUNT_BITS-1:0] r_found_count;
    logic [UW-1:0]         r_used;
    logic                  r_free_found;
    logic [IW-1:0]         r_free_idx;
    logic                  r_vic_found;
    logic [IW-1:0]         r_vic_idx;
    logic [KEY_BITS-1:0]   r_vic_key;
    logic [COUNT_BITS-1:0] r_vic_count;
    logic [STAMP_BITS-1:0] r_vic_stamp;

    logic                  r_done;
    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_read_value;
    logic                  r_evicted;
    logic [KEY_BITS-1:0]   r_evicted_key;
    logic                  r_refused;

    logic                  slot_live;
    logic                  vic_better;
    logic                  full;
    logic                  evict;
    logic                  do_insert;
    logic [IW-1:0]         ins_idx;
    logic [COUNT_BITS-1:0] bumped_count;

    assign o_stat.refuse    = (i_mode == MODE_PUT) && (r_capacity == '0);
    assign o_stat.scan_done = r_cmp_vld && (r_cmp_idx == LAST_IDX);

    assign slot_live  = r_cmp_vld && r_valid[r_cmp_idx];
    assign vic_better = !r_vic_found || (r_rd_count < r_vic_count)
                        || ((r_rd_count == r_vic_count) && (r_rd_stamp < r_vic_stamp));

    // used >= min(capacity, ENTRIES)
    assign full = (CMPW'(r_used) >= CMPW'(r_capacity)) || (r_used >= UW'(ENTRIES));
    assign evict     = !r_found && r_put && full && r_vic_found;
    assign do_insert = !r_found && r_put && !r_refuse;
    assign ins_idx   = (evict && (!r_free_found || (r_vic_idx < r_free_idx)))
                       ? r_vic_idx : r_free_idx;
    assign bumped_count = (r_found_count == '1) ? r_found_count
                                                : r_found_count + COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // request latch and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_put        <= (i_mode == MODE_PUT);
            r_refuse     <= o_stat.refuse;
            r_key        <= i_key;
            r_value      <= i_value;
            r_addr       <= '0;
            r_found      <= 1'b0;
            r_used       <= '0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else begin
            if (i_cmd.scan && r_issue) begin
                r_addr <= r_addr + IW'(1);
            end
            if (r_cmp_vld) begin
                if (slot_live) begin
                    r_used <= r_used + UW'(1);
                    if (!r_found && r_rd_key == r_key) begin
                        r_found       <= 1'b1;
                        r_found_idx   <= r_cmp_idx;
                        r_found_value <= r_rd_value;
                        r_found_count <= r_rd_count;
                    end
                    if (vic_better) begin
                        r_vic_found <= 1'b1;
                        r_vic_idx   <= r_cmp_idx;
                        r_vic_key   <= r_rd_key;
                        r_vic_count <= r_rd_count;
                        r_vic_stamp <= r_rd_stamp;
                    end
                end else if (!r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
            end
        end
        r_cmp_idx <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan && r_issue;
            if (i_cmd.load) begin
                r_issue <= 1'b1;
            end else if (i_cmd.scan && r_addr == LAST_IDX) begin
                r_issue <= 1'b0;
            end
        end
    end

    // memory read port, one slot per cycle
    always_ff @(posedge i_clk) begin
        r_rd_key   <= r_mem_key[r_addr];
        r_rd_value <= r_mem_value[r_addr];
        r_rd_count <= r_mem_count[r_addr];
        r_rd_stamp <= r_mem_stamp[r_addr];
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_refuse) begin
            if (r_found) begin
                r_mem_count[r_found_idx] <= bumped_count;
                r_mem_stamp[r_found_idx] <= r_stamp;
                if (r_put) begin
                    r_mem_value[r_found_idx] <= r_value;
                end
            end else if (r_put) begin
                r_mem_key[ins_idx]   <= r_key;
                r_mem_value[ins_idx] <= r_value;
                r_mem_count[ins_idx] <= COUNT_BITS'(1);
                r_mem_stamp[ins_idx] <= r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_stamp <= '0;
        end else if (i_cmd.commit && !r_refuse) begin
            if (r_found || r_put) begin
                r_stamp <= r_stamp + STAMP_BITS'(1);
            end
            // a victim slot reused by the insert simply stays valid
            if (evict && (ins_idx != r_vic_idx)) begin
                r_valid[r_vic_idx] <= 1'b0;
            end
            if (do_insert) begin
                r_valid[ins_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
        end
        if (i_cmd.commit) begin
            r_hit         <= !r_refuse && r_found;
            r_read_value  <= (!r_refuse && r_found && !r_put) ? r_found_value : '0;
            r_evicted     <= !r_refuse && evict;
            r_evicted_key <= (!r_refuse && evict) ? r_vic_key : '0;
            r_refused     <= r_refuse;
        end
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;
    assign o_refused     = r_refused;

    a_outcome_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_hit && o_evicted) && !(o_refused && (o_hit || o_evicted)))
        else $error("conflicting result flags");

    a_insert_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && do_insert) |-> (r_free_found || evict))
        else $error("insert without a free or evicted slot");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && do_insert && !evict) |-> !r_valid[ins_idx])
        else $error("insert over a live slot");

endmodule
`default_nettype wire

// File: hdl/lfu_cache_lookup_insert.sv
// Top level of the LFU cache: controller plus datapath.
//
// Usage: drive i_mode (0 get, 1 put), i_key and i_value and raise start. The
// request is taken at a clock edge where start is high and busy is low. One
// result comes back per request: o_done is high for exactly one cycle with
// o_hit, o_read_value, o_evicted, o_evicted_key and o_refused valid. The
// receiver cannot hold a result off; it must take it in that cycle.
// Operation: a request scans every slot through one memory read port, one
// slot per cycle, through a registered read, then writes back; busy stays
// high through it and o_done is registered from the write-back, so a new
// request is taken only once the last has finished, at the earliest while
// its o_done is high. A put refused at capacity zero skips the scan. The
// user must write capacity through i_cfg_we / i_cfg_wdata only while the
// block is idle; the block itself does not enforce it.
// Reset (i_rst_n low, synchronous) empties the cache, clears the age stamp,
// sets capacity to 16 and drops any request in flight; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_lookup_insert
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_mode,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_cfg_we,
    input  wire logic [CAP_BITS-1:0]   i_cfg_wdata,
    output logic                       o_done,
    output logic                       o_hit,
    output logic [VALUE_BITS-1:0]      o_read_value,
    output logic                       o_evicted,
    output logic [KEY_BITS-1:0]        o_evicted_key,
    output logic                       o_refused
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lfu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    lfu_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .o_refused     (o_refused)
    );

endmodule
`default_nettype wire

// File: sim/lfu_cache_lookup_insert_tb.sv
// Self-checking testbench for the LFU cache lookup/insert block.
`timescale 1ns / 1ps
module lfu_cache_lookup_insert_tb
    import lfu_pkg::*;
();

    localparam int ENTRIES        = 16;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int CNT_W          = 3;    // narrow counts so saturation is reachable
    localparam int WATCHDOG_LIMIT = 400;
    localparam int EXP_DEPTH      = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic             refused;
    } t_lfu_answer;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_mode;
    logic [KEY_W-1:0]    i_key;
    logic [VAL_W-1:0]    i_value;
    logic                i_cfg_we;
    logic [CAP_BITS-1:0] i_cfg_wdata;
    logic                o_done;
    logic                o_hit;
    logic [VAL_W-1:0]    o_read_value;
    logic                o_evicted;
    logic [KEY_W-1:0]    o_evicted_key;
    logic                o_refused;

    lfu_cache_lookup_insert #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_W),
        .VALUE_BITS(VAL_W),
        .COUNT_BITS(CNT_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .o_evicted    (o_evicted),
        .o_evicted_key(o_evicted_key),
        .o_refused    (o_refused)
    );

    // mirror of the cache contents
    logic                slot_valid [ENTRIES];
    logic [KEY_W-1:0]    slot_key   [ENTRIES];
    logic [VAL_W-1:0]    slot_val   [ENTRIES];
    logic [CNT_W-1:0]    slot_cnt   [ENTRIES];
    logic [47:0]         slot_stamp [ENTRIES];
    logic [47:0]         stamp_ctr;
    logic [CNT_W-1:0]    low_cnt;
    logic [CAP_BITS-1:0] cap_reg;

    // expected answers, oldest at exp_rd
    t_lfu_answer exp_mem[EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    int          errors;
    int          idle_cycles;
    logic [KEY_W-1:0] key_pool[24];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One get or put applied to the mirror; returns the answer it must produce.
    function automatic t_lfu_answer cache_access(input logic put,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [VAL_W-1:0] v);
        t_lfu_answer      a;
        int               i;
        int               found;
        int               used;
        int               victim;
        int               eff_cap;
        logic [CNT_W-1:0] c;
        logic             others;
        logic             placed;
        a       = '0;
        found   = -1;
        used    = 0;
        victim  = -1;
        others  = 1'b0;
        placed  = 1'b0;
        eff_cap = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
        if (put && eff_cap == 0) begin
            a.refused = 1'b1;
            return a;
        end
        for (i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) begin
                used++;
                if (found < 0 && slot_key[i] == k) found = i;
            end
        end
        if (found >= 0) begin
            a.hit = 1'b1;
            c = slot_cnt[found];
            slot_stamp[found] = stamp_ctr;
            stamp_ctr = stamp_ctr + 48'd1;
            if (c != CNT_MAX) begin
                slot_cnt[found] = c + 1'b1;
                // last member of the lowest group moved up: lowest rises
                if (c == low_cnt) begin
                    for (i = 0; i < ENTRIES; i++)
                        if (i != found && slot_valid[i] && slot_cnt[i] == c) others = 1'b1;
                    if (!others && low_cnt != CNT_MAX) low_cnt = low_cnt + 1'b1;
                end
            end
            if (put) slot_val[found] = v;
            else     a.read_value = slot_val[found];
            return a;
        end
        if (!put) return a;
        if (used >= eff_cap) begin
            for (i = 0; i < ENTRIES; i++) begin
                if (slot_valid[i]) begin
                    if (victim < 0 || slot_cnt[i] < slot_cnt[victim] ||
                        (slot_cnt[i] == slot_cnt[victim] &&
                         slot_stamp[i] < slot_stamp[victim]))
                        victim = i;
                end
            end
            if (victim >= 0) begin
                slot_valid[victim] = 1'b0;
                a.evicted     = 1'b1;
                a.evicted_key = slot_key[victim];
            end
        end
        for (i = 0; i < ENTRIES; i++) begin
            if (!placed && !slot_valid[i]) begin
                placed        = 1'b1;
                slot_valid[i] = 1'b1;
                slot_key[i]   = k;
                slot_val[i]   = v;
                slot_cnt[i]   = CNT_W'(1);
                slot_stamp[i] = stamp_ctr;
                stamp_ctr     = stamp_ctr + 48'd1;
            end
        end
        low_cnt = CNT_W'(1);
        return a;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result checking, request capture and capacity tracking, all at the rising edge.
    always @(posedge i_clk) begin
        t_lfu_answer exp_a;
        if (i_rst_n) begin
            if (o_done) begin
                if (exp_wr == exp_rd) begin
                    $display("%0t: result with no request outstanding", $time);
                    errors++;
                end else begin
                    exp_a = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    report_field("hit", 32'(exp_a.hit), 32'(o_hit));
                    report_field("read_value", exp_a.read_value, o_read_value);
                    report_field("evicted", 32'(exp_a.evicted), 32'(o_evicted));
                    report_field("evicted_key", exp_a.evicted_key, o_evicted_key);
                    report_field("refused", 32'(exp_a.refused), 32'(o_refused));
                end
            end
            if (start && !busy) begin
                exp_mem[exp_wr % EXP_DEPTH] = cache_access(i_mode, i_key, i_value);
                exp_wr++;
                idle_cycles = 0;
            end else if (o_done) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (i_cfg_we) cap_reg = i_cfg_wdata;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("[lfu_cache_lookup_insert] ERROR");
        $finish;
    end

    // Present one request and hold it until the block takes it.
    task automatic send_req(input logic m, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v);
        @(negedge i_clk);
        start   = 1'b1;
        i_mode  = m;
        i_key   = k;
        i_value = v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_sender(input int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain;
        @(negedge i_clk);
        start = 1'b0;
        while (exp_wr != exp_rd || busy) @(negedge i_clk);
    endtask

    // capacity is only written with the block idle and nothing outstanding
    task automatic set_capacity(input logic [CAP_BITS-1:0] c);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = c;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic test_empty_lookups;
        send_req(MODE_GET, '0, '1);
        send_req(MODE_GET, '1, '0);
    endtask

    task automatic test_insert_update;
        send_req(MODE_PUT, '0, '1);
        send_req(MODE_PUT, '1, '0);
        send_req(MODE_GET, '0, '0);
        send_req(MODE_GET, '1, '1);
        send_req(MODE_PUT, '0, 32'h1234_5678);
    endtask

    task automatic test_eviction;
        set_capacity(5'd2);
        send_req(MODE_PUT, 32'hA000_0001, 32'h0000_00A1);
        send_req(MODE_PUT, 32'hB000_0002, 32'h0000_00B2);
        send_req(MODE_GET, 32'hA000_0001, '0);
        send_req(MODE_PUT, 32'hC000_0003, 32'h0000_00C3);
        send_req(MODE_GET, 32'hB000_0002, '0);
    endtask

    // zero capacity: puts bounce, gets still served from what is stored
    task automatic test_refused_put;
        set_capacity(5'd0);
        send_req(MODE_PUT, 32'hD000_0004, 32'hDEAD_BEEF);
        send_req(MODE_GET, 32'hA000_0001, '0);
    endtask

    task automatic test_count_saturation;
        set_capacity(5'd31);
        send_req(MODE_PUT, 32'h5A5A_A5A5, 32'h0F0F_F0F0);
        repeat (CNT_MAX) send_req(MODE_GET, 32'h5A5A_A5A5, '0);
    endtask

    // lowered below occupancy: each miss evicts a single entry
    task automatic test_shrink_capacity;
        set_capacity(5'd1);
        send_req(MODE_PUT, 32'h0E00_0005, 32'h0000_0E05);
        send_req(MODE_PUT, 32'h0F00_0006, 32'h0000_0F06);
    endtask

    task automatic send_random(input int pool_n);
        logic             m;
        logic [KEY_W-1:0] k;
        m = ($urandom_range(0, 9) < 4) ? MODE_PUT : MODE_GET;
        k = ($urandom_range(0, 6) == 0) ? KEY_W'($urandom)
                                         : key_pool[$urandom_range(0, pool_n - 1)];
        send_req(m, k, VAL_W'($urandom));
    endtask

    task automatic test_random_traffic;
        int caps[9] = '{16, 31, 1, 5, 10, 0, 3, 17, 16};
        int p;
        int sent;
        int burst;
        int eff;
        int pool_n;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (p = 2; p < 24; p++) key_pool[p] = $urandom;
        for (p = 0; p < 9; p++) begin
            set_capacity(CAP_BITS'(caps[p]));
            eff    = (caps[p] > ENTRIES) ? ENTRIES : caps[p];
            pool_n = (eff < 1) ? 4 : eff + 4;
            sent   = 0;
            while (sent < 50) begin
                burst = $urandom_range(1, 8);
                repeat (burst) begin
                    if (sent < 50) begin
                        send_random(pool_n);
                        sent++;
                    end
                end
                if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 30));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_mode      = MODE_GET;
        i_key       = '0;
        i_value     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        errors      = 0;
        idle_cycles = 0;
        exp_wr      = 0;
        exp_rd      = 0;
        stamp_ctr   = '0;
        low_cnt     = '0;
        cap_reg     = CAP_RESET;
        for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_lookups();
        test_insert_update();
        test_eviction();
        test_refused_put();
        test_count_saturation();
        test_shrink_capacity();
        test_random_traffic();

        drain();
        repeat (ENTRIES + 5) @(posedge i_clk);
        if (errors == 0 && exp_wr == exp_rd)
            $display("[lfu_cache_lookup_insert] OK");
        else
            $display("[lfu_cache_lookup_insert] ERROR");
        $finish;
    end

endmodule

// File: lfu_cache_lookup_insert.f
hdl/lfu_pkg.sv
hdl/lfu_ctrl.sv
hdl/lfu_dp.sv
hdl/lfu_cache_lookup_insert.sv
sim/lfu_cache_lookup_insert_tb.sv
